// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on i_clk, disabled during reset.
`define SRQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on i_clk, disabled during reset.
`define SRQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/srq_pkg.sv
// Package for the segment to ribbon quad block: types, constants, helpers.
`timescale 1ns / 1ps
package srq_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int NORM_STEPS = 5;

    // side line stage indexes
    localparam int IDX_NORM_DONE = NORM_STEPS + 1;
    localparam int IDX_RSUM      = IDX_NORM_DONE + 1;
    localparam int IDX_SQRT_LAST = IDX_RSUM + SQRT_STEPS;
    localparam int IDX_DIV_FIRST = IDX_SQRT_LAST + 1;
    localparam int IDX_DIV_LAST  = IDX_SQRT_LAST + DIV_STEPS;
    localparam int IDX_MULT      = IDX_DIV_LAST + 1;
    localparam int IDX_OFFS      = IDX_MULT + 1;

    localparam logic [16:0] U_ONE   = 17'd65536;
    localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

    // vertex slots of one quad
    localparam logic [2:0] VTX_0 = 3'd0;
    localparam logic [2:0] VTX_1 = 3'd1;
    localparam logic [2:0] VTX_2 = 3'd2;
    localparam logic [2:0] VTX_3 = 3'd3;
    localparam logic [2:0] VTX_4 = 3'd4;
    localparam logic [2:0] VTX_5 = 3'd5;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
        logic [30:0]        w;
        logic               neg_dz;
        logic               pos_dx;
        logic               dir_nz;
        logic               len_sat;
        logic [30:0]        nax;
        logic [30:0]        naz;
        logic [30:0]        len;
    } t_side;

    // clamp a 33-bit signed sum to the 32-bit range
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/srq_norm_cell.sv
// Normalizing cell: conditional left shift of both magnitudes and their maximum by a fixed amount.
`timescale 1ns / 1ps
module srq_norm_cell
    import srq_pkg::*;
#(
    parameter int SHIFT = 16
) (
    input  logic        i_clk,
    input  logic [30:0] i_x,
    input  logic [30:0] i_z,
    input  logic [30:0] i_m,
    output logic [30:0] o_x,
    output logic [30:0] o_z,
    output logic [30:0] o_m
);
    logic w_go;

    // shift while the larger magnitude stays below 2^31
    assign w_go = (i_m[30:31-SHIFT] == '0);

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            o_x <= i_x << SHIFT;
            o_z <= i_z << SHIFT;
            o_m <= i_m << SHIFT;
        end else begin
            o_x <= i_x;
            o_z <= i_z;
            o_m <= i_m;
        end
    end
endmodule

// File: sv/srq_sqrt_cell.sv
// Square root cell: one result bit of a digit-by-digit integer square root.
`timescale 1ns / 1ps
module srq_sqrt_cell
    import srq_pkg::*;
#(
    parameter int K = 31
) (
    input  logic        i_clk,
    input  logic [63:0] i_x,
    input  logic [63:0] i_res,
    output logic [63:0] o_x,
    output logic [63:0] o_res
);
    localparam logic [64:0] BIT = 65'd1 << (2 * K);
    logic [64:0] w_trial;

    assign w_trial = {1'b0, i_res} + BIT;

    always_ff @(posedge i_clk) begin
        if ({1'b0, i_x} >= w_trial) begin
            o_x   <= i_x - w_trial[63:0];
            o_res <= (i_res >> 1) + BIT[63:0];
        end else begin
            o_x   <= i_x;
            o_res <= i_res >> 1;
        end
    end
endmodule

// File: sv/srq_div_cell.sv
// Divider cell: one quotient bit of a restoring division.
`timescale 1ns / 1ps
module srq_div_cell
    import srq_pkg::*;
#(
    parameter int J = 30
) (
    input  logic        i_clk,
    input  logic [61:0] i_rem,
    input  logic [30:0] i_q,
    input  logic [31:0] i_d,
    output logic [61:0] o_rem,
    output logic [30:0] o_q,
    output logic [31:0] o_d
);
    logic [62:0] w_dsh;

    assign w_dsh = {31'd0, i_d} << J;

    always_ff @(posedge i_clk) begin
        o_d <= i_d;
        if ({1'b0, i_rem} >= w_dsh) begin
            o_rem <= i_rem - w_dsh[61:0];
            o_q   <= i_q | (31'd1 << J);
        end else begin
            o_rem <= i_rem;
            o_q   <= i_q;
        end
    end
endmodule

// File: sv/segment_to_ribbon_quad_top.sv
// Top level: expands a 3D segment into six ribbon quad vertices.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  segment   | start / busy           | i_start_x..z, i_end_x..z, i_width
//  vertex    | o_valid (no backpress) | o_pos_x..z, o_tex_u, o_tex_v,
//            |                        | o_last_vertex
//
// A new segment can be accepted while earlier ones are still in the pipeline;
// busy is high after each accept until the gap counter runs down. Results
// cannot be stalled: the six vertices leave on one output port, one per cycle.
// Cell chains: 5 normalize cells, then 32 square root and 31 divider cells in
// each paired chain. Reset (synchronous, active low) clears the gap counter,
// the valid line and the vertex sequencer; cell payload is not reset.
`timescale 1ns / 1ps
module segment_to_ribbon_quad_top
    import srq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    input  logic [30:0]        i_width,
    output logic               o_valid,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [16:0]        o_tex_u,
    output logic [30:0]        o_tex_v,
    output logic               o_last_vertex
);
`include "assert_macros.svh"

    // accept gap counter
    logic [2:0] r_gap;
    logic       w_acc;
    assign busy  = (r_gap != 3'd0);
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 3'd0;
        end else if (w_acc) begin
            r_gap <= 3'd5;
        end else if (r_gap != 3'd0) begin
            r_gap <= r_gap - 3'd1;
        end
    end

    // stage a: capture
    t_side r_a;
    t_side n_a;
    logic  r_va;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= w_acc;
        end
    end
    always_comb begin
        n_a    = '0;
        n_a.sx = i_start_x;
        n_a.sy = i_start_y;
        n_a.sz = i_start_z;
        n_a.ex = i_end_x;
        n_a.ey = i_end_y;
        n_a.ez = i_end_z;
        n_a.w  = i_width;
    end
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a <= n_a;
        end
    end

    // stage b: direction, magnitudes, flags
    logic signed [32:0] w_dx, w_dy, w_dz;
    logic [32:0]        w_mx, w_my, w_mz;
    t_side              r_b;
    t_side              n_b;
    logic               r_vb;
    logic [31:0]        r_bax, r_bay, r_baz;

    assign w_dx = {r_a.ex[31], r_a.ex} - {r_a.sx[31], r_a.sx};
    assign w_dy = {r_a.ey[31], r_a.ey} - {r_a.sy[31], r_a.sy};
    assign w_dz = {r_a.ez[31], r_a.ez} - {r_a.sz[31], r_a.sz};
    assign w_mx = w_dx[32] ? -w_dx : w_dx;
    assign w_my = w_dy[32] ? -w_dy : w_dy;
    assign w_mz = w_dz[32] ? -w_dz : w_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
    end
    always_comb begin
        n_b         = r_a;
        n_b.neg_dz  = w_dz[32];
        n_b.pos_dx  = !w_dx[32] && (w_dx != '0);
        n_b.dir_nz  = (w_dx != '0) || (w_dz != '0);
        n_b.len_sat = w_mx[31] || w_my[31] || w_mz[31];
    end
    always_ff @(posedge i_clk) begin
        r_b   <= n_b;
        r_bax <= w_mx[31:0];
        r_bay <= w_my[31:0];
        r_baz <= w_mz[31:0];
    end

    // side line from stage c to the offset stage
    t_side r_sl [0:IDX_OFFS];
    t_side n_sl [1:IDX_OFFS];
    logic  r_vl [0:IDX_OFFS];

    // stage c: length squares and pre-normalize
    logic [31:0] w_cm;
    logic [61:0] r_clx, r_cly, r_clz;
    logic [30:0] w_nx [0:NORM_STEPS];
    logic [30:0] w_nz [0:NORM_STEPS];
    logic [30:0] w_nm [0:NORM_STEPS];
    logic [30:0] r_cnx, r_cnz, r_cnm;

    assign w_cm = (r_bax > r_baz) ? r_bax : r_baz;

    always_ff @(posedge i_clk) begin
        r_clx   <= r_bax[30:0] * r_bax[30:0];
        r_cly   <= r_bay[30:0] * r_bay[30:0];
        r_clz   <= r_baz[30:0] * r_baz[30:0];
        if (w_cm[31]) begin
            r_cnx <= r_bax[31:1];
            r_cnz <= r_baz[31:1];
            r_cnm <= w_cm[31:1];
        end else begin
            r_cnx <= r_bax[30:0];
            r_cnz <= r_baz[30:0];
            r_cnm <= w_cm[30:0];
        end
    end

    assign w_nx[0] = r_cnx;
    assign w_nz[0] = r_cnz;
    assign w_nm[0] = r_cnm;

    // normalize chain: shifts of 16, 8, 4, 2, 1
    for (genvar i = 0; i < NORM_STEPS; i++) begin : g_norm
        srq_norm_cell #(.SHIFT(16 >> i)) u_norm (
            .i_clk (i_clk),
            .i_x   (w_nx[i]),
            .i_z   (w_nz[i]),
            .i_m   (w_nm[i]),
            .o_x   (w_nx[i+1]),
            .o_z   (w_nz[i+1]),
            .o_m   (w_nm[i+1])
        );
    end

    // length sum, delayed to meet the square root chain
    logic [63:0] r_ls [1:IDX_RSUM];
    always_ff @(posedge i_clk) begin
        r_ls[1] <= {2'b00, r_clx} + {2'b00, r_cly} + {2'b00, r_clz};
        for (int k = 2; k <= IDX_RSUM; k++) begin
            r_ls[k] <= r_ls[k-1];
        end
    end

    // normal radius squares and sum
    logic [61:0] r_rx2, r_rz2;
    logic [63:0] r_rsum;
    always_ff @(posedge i_clk) begin
        r_rx2  <= w_nx[NORM_STEPS] * w_nx[NORM_STEPS];
        r_rz2  <= w_nz[NORM_STEPS] * w_nz[NORM_STEPS];
        r_rsum <= {2'b00, r_rx2} + {2'b00, r_rz2};
    end

    // square root chains: normal radius and segment length side by side
    logic [63:0] w_rx [0:SQRT_STEPS];
    logic [63:0] w_rr [0:SQRT_STEPS];
    logic [63:0] w_lx [0:SQRT_STEPS];
    logic [63:0] w_lr [0:SQRT_STEPS];
    assign w_rx[0] = r_rsum;
    assign w_rr[0] = '0;
    assign w_lx[0] = r_ls[IDX_RSUM];
    assign w_lr[0] = '0;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        srq_sqrt_cell #(.K(SQRT_STEPS - 1 - i)) u_rad (
            .i_clk (i_clk),
            .i_x   (w_rx[i]),
            .i_res (w_rr[i]),
            .o_x   (w_rx[i+1]),
            .o_res (w_rr[i+1])
        );
        srq_sqrt_cell #(.K(SQRT_STEPS - 1 - i)) u_len (
            .i_clk (i_clk),
            .i_x   (w_lx[i]),
            .i_res (w_lr[i]),
            .o_x   (w_lx[i+1]),
            .o_res (w_lr[i+1])
        );
    end

    // divider chains: unit normal components
    logic [61:0] w_xrem [0:DIV_STEPS];
    logic [30:0] w_xq   [0:DIV_STEPS];
    logic [31:0] w_xd   [0:DIV_STEPS];
    logic [61:0] w_zrem [0:DIV_STEPS];
    logic [30:0] w_zq   [0:DIV_STEPS];
    logic [31:0] w_zd   [0:DIV_STEPS];
    // nx from |dz'|, nz from |dx'|
    assign w_xrem[0] = {1'b0, r_sl[IDX_SQRT_LAST].naz, 30'd0};
    assign w_zrem[0] = {1'b0, r_sl[IDX_SQRT_LAST].nax, 30'd0};
    assign w_xq[0]   = '0;
    assign w_zq[0]   = '0;
    assign w_xd[0]   = w_rr[SQRT_STEPS][31:0];
    assign w_zd[0]   = w_rr[SQRT_STEPS][31:0];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        srq_div_cell #(.J(DIV_STEPS - 1 - j)) u_divx (
            .i_clk (i_clk),
            .i_rem (w_xrem[j]),
            .i_q   (w_xq[j]),
            .i_d   (w_xd[j]),
            .o_rem (w_xrem[j+1]),
            .o_q   (w_xq[j+1]),
            .o_d   (w_xd[j+1])
        );
        srq_div_cell #(.J(DIV_STEPS - 1 - j)) u_divz (
            .i_clk (i_clk),
            .i_rem (w_zrem[j]),
            .i_q   (w_zq[j]),
            .i_d   (w_zd[j]),
            .o_rem (w_zrem[j+1]),
            .o_q   (w_zq[j+1]),
            .o_d   (w_zd[j+1])
        );
    end

    // side line next values: normalized magnitudes and saturated length
    always_comb begin
        for (int k = 1; k <= IDX_OFFS; k++) begin
            n_sl[k] = r_sl[k-1];
            if (k == IDX_NORM_DONE) begin
                n_sl[k].nax = w_nx[NORM_STEPS];
                n_sl[k].naz = w_nz[NORM_STEPS];
            end
            if (k == IDX_DIV_FIRST) begin
                if (r_sl[k-1].len_sat || (w_lr[SQRT_STEPS][63:31] != '0)) begin
                    n_sl[k].len = LEN_MAX;
                end else begin
                    n_sl[k].len = w_lr[SQRT_STEPS][30:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sl[0] <= r_b;
        for (int k = 1; k <= IDX_OFFS; k++) begin
            r_sl[k] <= n_sl[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= IDX_OFFS; k++) begin
                r_vl[k] <= 1'b0;
            end
        end else begin
            r_vl[0] <= r_vb;
            for (int k = 1; k <= IDX_OFFS; k++) begin
                r_vl[k] <= r_vl[k-1];
            end
        end
    end

    // half thickness products
    logic [61:0] r_px, r_pz;
    always_ff @(posedge i_clk) begin
        r_px <= r_sl[IDX_DIV_LAST].w * w_xq[DIV_STEPS];
        r_pz <= r_sl[IDX_DIV_LAST].w * w_zq[DIV_STEPS];
    end

    // rounded signed offsets
    logic [62:0]        w_rx_rnd, w_rz_rnd;
    logic signed [31:0] w_mox, w_moz;
    logic signed [31:0] r_ox, r_oz;
    assign w_rx_rnd = {1'b0, r_px} + (63'd1 << 30);
    assign w_rz_rnd = {1'b0, r_pz} + (63'd1 << 30);
    assign w_mox    = w_rx_rnd[62:31];
    assign w_moz    = w_rz_rnd[62:31];

    always_ff @(posedge i_clk) begin
        if (!r_sl[IDX_MULT].dir_nz) begin
            r_ox <= '0;
            r_oz <= '0;
        end else begin
            r_ox <= r_sl[IDX_MULT].neg_dz ? -w_mox : w_mox;
            r_oz <= r_sl[IDX_MULT].pos_dx ? -w_moz : w_moz;
        end
    end

    // corner positions, saturated
    t_side              w_so;
    logic signed [32:0] w_oxe, w_oze;
    assign w_so  = r_sl[IDX_OFFS];
    assign w_oxe = {r_ox[31], r_ox};
    assign w_oze = {r_oz[31], r_oz};

    logic signed [31:0] r_p0x, r_p0z, r_p1x, r_p1z, r_p2x, r_p2z, r_p3x, r_p3z;
    logic signed [31:0] r_hsy, r_hey;
    logic [30:0]        r_hlen;
    logic               r_emit;
    logic [2:0]         r_vcnt;

    always_ff @(posedge i_clk) begin
        if (r_vl[IDX_OFFS]) begin
            r_p0x  <= sat33({w_so.sx[31], w_so.sx} + w_oxe);
            r_p0z  <= sat33({w_so.sz[31], w_so.sz} + w_oze);
            r_p1x  <= sat33({w_so.ex[31], w_so.ex} + w_oxe);
            r_p1z  <= sat33({w_so.ez[31], w_so.ez} + w_oze);
            r_p2x  <= sat33({w_so.sx[31], w_so.sx} - w_oxe);
            r_p2z  <= sat33({w_so.sz[31], w_so.sz} - w_oze);
            r_p3x  <= sat33({w_so.ex[31], w_so.ex} - w_oxe);
            r_p3z  <= sat33({w_so.ez[31], w_so.ez} - w_oze);
            r_hsy  <= w_so.sy;
            r_hey  <= w_so.ey;
            r_hlen <= w_so.len;
        end
    end

    // vertex sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
            r_vcnt <= VTX_0;
        end else if (r_vl[IDX_OFFS]) begin
            r_emit <= 1'b1;
            r_vcnt <= VTX_0;
        end else if (r_emit) begin
            if (r_vcnt == VTX_5) begin
                r_emit <= 1'b0;
                r_vcnt <= VTX_0;
            end else begin
                r_vcnt <= r_vcnt + 3'd1;
            end
        end
    end

    // vertex order: P3, P1, P0, P3, P0, P2
    assign o_valid = r_emit;
    always_comb begin
        o_last_vertex = 1'b0;
        case (r_vcnt)
            VTX_0, VTX_3: begin
                o_pos_x = r_p3x; o_pos_y = r_hey; o_pos_z = r_p3z;
                o_tex_u = '0;    o_tex_v = '0;
            end
            VTX_1: begin
                o_pos_x = r_p1x; o_pos_y = r_hey; o_pos_z = r_p1z;
                o_tex_u = U_ONE; o_tex_v = '0;
            end
            VTX_2, VTX_4: begin
                o_pos_x = r_p0x; o_pos_y = r_hsy; o_pos_z = r_p0z;
                o_tex_u = U_ONE; o_tex_v = r_hlen;
            end
            VTX_5: begin
                o_pos_x = r_p2x; o_pos_y = r_hsy; o_pos_z = r_p2z;
                o_tex_u = '0;    o_tex_v = r_hlen;
                o_last_vertex = 1'b1;
            end
            default: begin
                o_pos_x = r_p3x; o_pos_y = r_hey; o_pos_z = r_p3z;
                o_tex_u = '0;    o_tex_v = '0;
            end
        endcase
    end

    // checks
    `SRQ_ASSERT_NXT(a_busy_after_accept, w_acc, busy)
    `SRQ_ASSERT_NXT(a_quad_runs_on, o_valid && !o_last_vertex, o_valid)
    `SRQ_ASSERT_IMP(a_last_after_five, o_last_vertex, o_valid && $past(o_valid, 5))
    `SRQ_ASSERT_IMP(a_no_reload_mid_quad, r_vl[IDX_OFFS], !r_emit || (r_vcnt == VTX_5))

endmodule
